[rtl/core/lpd_pkg.sv]
// ----------------------------------------------------------------------------
// Length-prefixed deframer package
// Shared constants, codes and types of the deframer core.
// ----------------------------------------------------------------------------
package lpd_pkg;

    localparam int LENGTH_FIELD_BYTES = 4;
    localparam int TYPE_FIELD_BYTES   = 4;
    localparam int HEADER_BYTES       = LENGTH_FIELD_BYTES + TYPE_FIELD_BYTES;

    localparam int WORD_W      = 32;
    localparam int CFG_INDEX_W = 8;

    // Input function codes
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_BYTE  = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_LENGTH = 2'd1;
    localparam logic [1:0] STATUS_BAD_TYPE   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FRAME_LENGTH      = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_MESSAGE_TYPE = 8'd1;

    localparam logic [WORD_W-1:0] MAX_FRAME_LENGTH_RESET      = 32'd1048576;
    localparam logic [WORD_W-1:0] EXPECTED_MESSAGE_TYPE_RESET = 32'd6;

    typedef struct packed {
        logic length_bad;
        logic type_bad;
    } hdr_check_t;

endpackage

[rtl/core/lpd_if.sv]
// ----------------------------------------------------------------------------
// Length-prefixed deframer channels
// Stream input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface lpd_stream_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;

    modport source (output valid, output func, output data_byte, input ready);
    modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface lpd_result_if;
    logic                       valid;
    logic                       ready;
    logic                       accepted;
    logic                       payload_valid;
    logic [7:0]                 payload_byte;
    logic                       last_payload;
    logic                       frame_done;
    logic [1:0]                 status;
    logic [lpd_pkg::WORD_W-1:0] payload_count;

    modport source (output valid, output accepted, output payload_valid,
                    output payload_byte, output last_payload, output frame_done,
                    output status, output payload_count, input ready);
    modport sink   (input valid, input accepted, input payload_valid,
                    input payload_byte, input last_payload, input frame_done,
                    input status, input payload_count, output ready);
endinterface

interface lpd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lpd_pkg::CFG_INDEX_W-1:0] index;
    logic [lpd_pkg::WORD_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/lpd_hdr_check.sv]
// ----------------------------------------------------------------------------
// Header check
// Compares the header length and message type against the configuration.
// ----------------------------------------------------------------------------
module lpd_hdr_check (
    input  logic [lpd_pkg::WORD_W-1:0] hdr_len,
    input  logic [lpd_pkg::WORD_W-1:0] hdr_msg_type,
    input  logic [lpd_pkg::WORD_W-1:0] len_limit,
    input  logic [lpd_pkg::WORD_W-1:0] want_type,
    output lpd_pkg::hdr_check_t        check
);

    localparam logic [lpd_pkg::WORD_W-1:0] MIN_LENGTH =
        lpd_pkg::WORD_W'(lpd_pkg::TYPE_FIELD_BYTES);

    always_comb
    begin
        check.length_bad = (hdr_len < MIN_LENGTH) || (hdr_len > len_limit);
        check.type_bad   = (hdr_msg_type != want_type);
    end

endmodule

[rtl/core/length_prefixed_deframer_core.sv]
// ----------------------------------------------------------------------------
// Length-prefixed deframer core
// Result: registered; a result appears in the cycle after its word is accepted.
// Throughput: one word per cycle while no result is held waiting downstream;
// the state update and the header check are combinational between the state registers and the result register.
// Reset: asynchronous, clears the frame state and loads the register resets;
// the block is ready as soon as reset is released, with no clearing pass.
// ----------------------------------------------------------------------------
module length_prefixed_deframer_core (
    input  logic         clk,
    input  logic         rst_n,
    lpd_stream_if.sink   stream,
    lpd_result_if.source result,
    lpd_cfg_if.sink      cfg
);

    localparam int W  = lpd_pkg::WORD_W;
    localparam int LW = 8 * lpd_pkg::LENGTH_FIELD_BYTES;
    localparam int HW = 8 * lpd_pkg::HEADER_BYTES;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_ERROR   = 2'd3;

    localparam logic [3:0]   LAST_HDR_POS = 4'(lpd_pkg::HEADER_BYTES - 1);
    localparam logic [W-1:0] MIN_LENGTH   = W'(lpd_pkg::TYPE_FIELD_BYTES);

    logic [W-1:0]  max_len_reg;
    logic [W-1:0]  exp_type_reg;

    logic [1:0]    phase_reg, phase_next;
    logic [3:0]    hdr_count_reg, hdr_count_next;
    logic [HW-1:0] hdr_reg, hdr_next;
    logic [W-1:0]  remaining_reg, remaining_next;
    logic [W-1:0]  delivered_reg, delivered_next;

    logic          out_valid_reg;
    logic          accepted_reg, accepted_next;
    logic          pvalid_reg, pvalid_next;
    logic [7:0]    pbyte_reg, pbyte_next;
    logic          last_reg, last_next;
    logic          done_reg, done_next;
    logic [1:0]    status_reg, status_next;
    logic [W-1:0]  count_reg, count_next;

    logic          accept_in;
    logic          hdr_final;
    logic [W-1:0]  hdr_type;
    lpd_pkg::hdr_check_t chk;

    assign accept_in    = stream.valid && stream.ready;
    assign stream.ready = !out_valid_reg || result.ready;
    assign cfg.ready    = 1'b1;

    // On the last header byte the type is completed by the incoming byte.
    assign hdr_final = (hdr_count_reg == LAST_HDR_POS);
    assign hdr_type  = hdr_final ? {stream.data_byte, hdr_reg[HW-9:LW]} : hdr_reg[HW-1:LW];

    lpd_hdr_check u_hdr_check (
        .hdr_len      (hdr_reg[LW-1:0]),
        .hdr_msg_type (hdr_type),
        .len_limit    (max_len_reg),
        .want_type    (exp_type_reg),
        .check        (chk)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg  <= lpd_pkg::MAX_FRAME_LENGTH_RESET;
            exp_type_reg <= lpd_pkg::EXPECTED_MESSAGE_TYPE_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                lpd_pkg::CFG_MAX_FRAME_LENGTH:      max_len_reg  <= cfg.data;
                lpd_pkg::CFG_EXPECTED_MESSAGE_TYPE: exp_type_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        hdr_count_next = hdr_count_reg;
        hdr_next       = hdr_reg;
        remaining_next = remaining_reg;
        delivered_next = delivered_reg;

        accepted_next = 1'b0;
        pvalid_next   = 1'b0;
        pbyte_next    = 8'd0;
        last_next     = 1'b0;
        done_next     = 1'b0;
        status_next   = lpd_pkg::STATUS_OK;

        if (stream.func == lpd_pkg::FUNC_START)
        begin
            phase_next     = PH_HEADER;
            hdr_count_next = 4'd0;
            hdr_next       = '0;
            remaining_next = '0;
            delivered_next = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    hdr_next[{hdr_count_reg[2:0], 3'b000} +: 8] =
                        hdr_reg[{hdr_count_reg[2:0], 3'b000} +: 8] | stream.data_byte;
                    hdr_count_next = hdr_count_reg + 4'd1;
                    accepted_next  = 1'b1;
                    if (hdr_final)
                    begin
                        if (chk.length_bad)
                        begin
                            phase_next    = PH_ERROR;
                            accepted_next = 1'b0;
                            status_next   = lpd_pkg::STATUS_BAD_LENGTH;
                        end
                        else if (chk.type_bad)
                        begin
                            phase_next    = PH_ERROR;
                            accepted_next = 1'b0;
                            status_next   = lpd_pkg::STATUS_BAD_TYPE;
                        end
                        else
                        begin
                            remaining_next = hdr_reg[LW-1:0] - MIN_LENGTH;
                            if (hdr_reg[LW-1:0] == MIN_LENGTH)
                            begin
                                phase_next = PH_IDLE;
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    accepted_next  = 1'b1;
                    pvalid_next    = 1'b1;
                    pbyte_next     = stream.data_byte;
                    delivered_next = delivered_reg + W'(1);
                    if (remaining_reg != '0)
                    begin
                        remaining_next = remaining_reg - W'(1);
                    end
                    if (remaining_reg <= W'(1))
                    begin
                        last_next  = 1'b1;
                        done_next  = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
                PH_ERROR:
                begin
                    status_next = chk.length_bad ? lpd_pkg::STATUS_BAD_LENGTH
                                                 : lpd_pkg::STATUS_BAD_TYPE;
                end
                PH_IDLE: ;
                default: ;
            endcase
        end

        count_next = delivered_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            hdr_count_reg <= 4'd0;
            hdr_reg       <= '0;
            remaining_reg <= '0;
            delivered_reg <= '0;
        end
        else if (accept_in)
        begin
            phase_reg     <= phase_next;
            hdr_count_reg <= hdr_count_next;
            hdr_reg       <= hdr_next;
            remaining_reg <= remaining_next;
            delivered_reg <= delivered_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept_in)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload holds while a word waits downstream.
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            accepted_reg <= accepted_next;
            pvalid_reg   <= pvalid_next;
            pbyte_reg    <= pbyte_next;
            last_reg     <= last_next;
            done_reg     <= done_next;
            status_reg   <= status_next;
            count_reg    <= count_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.accepted      = accepted_reg;
    assign result.payload_valid = pvalid_reg;
    assign result.payload_byte  = pbyte_reg;
    assign result.last_payload  = last_reg;
    assign result.frame_done    = done_reg;
    assign result.status        = status_reg;
    assign result.payload_count = count_reg;

    // A payload phase always has at least one byte still to come.
    a_payload_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> remaining_reg != '0)
        else $error("payload phase with nothing remaining");

    // An error status never comes with a consumed word.
    a_error_not_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != lpd_pkg::STATUS_OK |-> !accepted_reg && !pvalid_reg)
        else $error("error status on an accepted word");

    // The header counter never runs past a full header while collecting.
    a_hdr_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HEADER |-> hdr_count_reg <= LAST_HDR_POS)
        else $error("header count out of range");

    // A payload word increments the frame's count.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in && stream.func == lpd_pkg::FUNC_BYTE && phase_reg == PH_PAYLOAD
        |=> delivered_reg == $past(delivered_reg) + W'(1))
        else $error("payload count did not advance");

endmodule
